>>> rtl/core/next_hop_arp_cache_defines.svh
// assertion macros for the next hop arp cache
`ifndef NEXT_HOP_ARP_CACHE_DEFINES_SVH
`define NEXT_HOP_ARP_CACHE_DEFINES_SVH

`ifndef SYNTH

`define NHA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("nha assertion failed");

`define NHA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("nha assertion failed");

`else

`define NHA_ASSERT_IMPL(label, clk, rst_n, ante, cons)

`define NHA_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/core/nha_pkg.sv
// shared types and constants of the next hop arp cache
package nha_pkg;

    localparam int IP_W      = 32;
    localparam int MAC_IN_W  = 48;
    localparam int AGE_W     = 32;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [IP_W-1:0]  BCAST_IP  = 32'hFFFF_FFFF;
    localparam logic [7:0]       BYTE_ONES = 8'hFF;
    localparam logic [AGE_W-1:0] AGE_MAX   = 32'hFFFF_FFFF;
    localparam logic [AGE_W-1:0] AGE_FIRST = 32'd1;

    localparam logic [1:0] REG_NET_MASK   = 2'd0;
    localparam logic [1:0] REG_GATEWAY    = 2'd1;
    localparam logic [1:0] REG_GW_PRESENT = 2'd2;

    localparam logic ACT_RESOLVE = 1'b0;
    localparam logic ACT_INSERT  = 1'b1;

    typedef struct packed {
        logic [IP_W-1:0] net_mask;
        logic [IP_W-1:0] gateway_addr;
        logic            gateway_present;
    } t_cfg;

endpackage

>>> rtl/core/nha_req_if.sv
// request channel carrying resolve and insert requests
interface nha_req_if;
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic [nha_pkg::IP_W-1:0]      ip_addr;
    logic [nha_pkg::MAC_IN_W-1:0]  mac_addr;

    modport source (output valid, action, ip_addr, mac_addr, input ready);
    modport sink   (input valid, action, ip_addr, mac_addr, output ready);
endinterface

>>> rtl/core/nha_rsp_if.sv
// result channel carrying found flag, mac and next hop
interface nha_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          found;
    logic [nha_pkg::MAC_IN_W-1:0]  mac_out;
    logic [nha_pkg::IP_W-1:0]      next_hop;

    modport source (output valid, found, mac_out, next_hop, input ready);
    modport sink   (input valid, found, mac_out, next_hop, output ready);
endinterface

>>> rtl/core/next_hop_arp_cache.sv
// next hop arp cache: entry scan through one memory, oldest entry replacement
// requests are accepted only in idle; the scan reads the entry memory one row per cycle
//   through its single read port, then the drain and finish states follow, and the result
//   registers load in finish once the output is free, so a new request waits until then
// reset: all entries empty at once (per-entry valid flops), age counter to one,
//   config registers to zero, no clearing pass
`include "next_hop_arp_cache_defines.svh"

module next_hop_arp_cache #(
    parameter int ENTRIES   = 8,
    parameter int MAC_BYTES = 6
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    nha_req_if.sink                           i_req,
    nha_rsp_if.source                         o_rsp,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [nha_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [nha_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [nha_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready
);
    localparam int MAC_KEEP = (MAC_BYTES > 6) ? 6 : MAC_BYTES;
    localparam int MAC_W    = 8 * MAC_KEEP;
    localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int IP_W     = nha_pkg::IP_W;
    localparam int AGE_W    = nha_pkg::AGE_W;
    localparam int ROW_W    = AGE_W + IP_W + MAC_W;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);
    localparam logic [MAC_W-1:0] MAC_BCAST = {MAC_KEEP{nha_pkg::BYTE_ONES}};

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } t_state;

    nha_pkg::t_cfg w_cfg;

    t_state              r_state;
    logic                r_action;
    logic [IP_W-1:0]     r_hop;
    logic [MAC_W-1:0]    r_mac_in;
    logic [IDX_W-1:0]    r_idx;
    logic                r_cmp_vld;
    logic [IDX_W-1:0]    r_cmp_idx;
    logic                r_hit;
    logic [MAC_W-1:0]    r_hit_mac;
    logic                r_empty_found;
    logic [IDX_W-1:0]    r_empty_idx;
    logic                r_min_any;
    logic [AGE_W-1:0]    r_min_age;
    logic [IDX_W-1:0]    r_min_idx;
    logic [ENTRIES-1:0]  r_valid;
    logic [AGE_W-1:0]    r_age_ctr;
    logic                r_out_vld;
    logic                r_out_found;
    logic [nha_pkg::MAC_IN_W-1:0] r_out_mac;
    logic [IP_W-1:0]     r_out_hop;

    logic                w_accept;
    logic                w_local;
    logic [IP_W-1:0]     w_hop;
    logic [ROW_W-1:0]    w_row;
    logic                w_row_vld;
    logic [AGE_W-1:0]    w_row_age;
    logic [IP_W-1:0]     w_row_ip;
    logic [MAC_W-1:0]    w_row_mac;
    logic                w_out_free;
    logic                w_done;
    logic                w_bcast;
    logic                w_found;
    logic [MAC_W-1:0]    w_mac_res;
    logic                w_wr_en;
    logic [IDX_W-1:0]    w_sel;
    logic [ROW_W-1:0]    w_wdata;

    nha_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // next hop selection at request accept
    assign w_local = (i_req.ip_addr == nha_pkg::BCAST_IP) ||
                     (((i_req.ip_addr ^ w_cfg.gateway_addr) & w_cfg.net_mask) == '0);
    assign w_hop   = ((i_req.action == nha_pkg::ACT_INSERT) || w_local ||
                      !w_cfg.gateway_present) ? i_req.ip_addr : w_cfg.gateway_addr;

    assign i_req.ready = (r_state == ST_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;

    // entry row: age, ip, mac
    assign w_row_vld = r_valid[r_cmp_idx];
    assign w_row_age = w_row[ROW_W-1 -: AGE_W];
    assign w_row_ip  = w_row[MAC_W +: IP_W];
    assign w_row_mac = w_row[MAC_W-1:0];

    assign w_out_free = !r_out_vld || o_rsp.ready;
    assign w_done     = (r_state == ST_FINISH) && w_out_free;
    assign w_bcast    = (r_hop == nha_pkg::BCAST_IP);
    assign w_found    = w_bcast || r_hit;
    assign w_mac_res  = w_bcast ? MAC_BCAST : (r_hit ? r_hit_mac : '0);
    assign w_sel      = r_empty_found ? r_empty_idx : r_min_idx;
    assign w_wr_en    = w_done && (r_action == nha_pkg::ACT_INSERT) && !w_found;
    assign w_wdata    = {r_age_ctr, r_hop, r_mac_in};

    nha_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ENTRIES)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (w_wr_en),
        .i_waddr (w_sel),
        .i_wdata (w_wdata),
        .i_raddr (r_idx),
        .o_rdata (w_row)
    );

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_idx     <= '0;
            r_cmp_vld <= 1'b0;
            r_valid   <= '0;
            r_age_ctr <= nha_pkg::AGE_FIRST;
            r_out_vld <= 1'b0;
        end else begin
            r_cmp_vld <= (r_state == ST_SCAN);
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_idx   <= '0;
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == IDX_LAST) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    r_state <= ST_FINISH;
                end
                ST_FINISH: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            if (w_wr_en) begin
                r_valid[w_sel] <= 1'b1;
                r_age_ctr <= (r_age_ctr == nha_pkg::AGE_MAX) ? nha_pkg::AGE_FIRST
                                                             : r_age_ctr + 1'b1;
            end
            if (w_done) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // request payload, scan accumulators and result register
    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_idx;
        if (w_accept) begin
            r_action      <= i_req.action;
            r_hop         <= w_hop;
            r_mac_in      <= i_req.mac_addr[MAC_W-1:0];
            r_hit         <= 1'b0;
            r_hit_mac     <= '0;
            r_empty_found <= 1'b0;
            r_empty_idx   <= '0;
            r_min_any     <= 1'b0;
            r_min_age     <= '0;
            r_min_idx     <= '0;
        end else if (r_cmp_vld) begin
            if (w_row_vld && (w_row_ip == r_hop) && !r_hit) begin
                r_hit     <= 1'b1;
                r_hit_mac <= w_row_mac;
            end
            if (!w_row_vld && !r_empty_found) begin
                r_empty_found <= 1'b1;
                r_empty_idx   <= r_cmp_idx;
            end
            if (w_row_vld && (!r_min_any || (w_row_age < r_min_age))) begin
                r_min_any <= 1'b1;
                r_min_age <= w_row_age;
                r_min_idx <= r_cmp_idx;
            end
        end
        if (w_done) begin
            r_out_found <= w_found;
            r_out_mac   <= nha_pkg::MAC_IN_W'(w_mac_res);
            r_out_hop   <= r_hop;
        end
    end

    assign o_rsp.valid    = r_out_vld;
    assign o_rsp.found    = r_out_found;
    assign o_rsp.mac_out  = r_out_mac;
    assign o_rsp.next_hop = r_out_hop;

    `NHA_ASSERT_NEXT(a_accept_starts_scan, i_clk, i_rst_n, w_accept, (r_state == ST_SCAN) && (r_idx == '0))
    `NHA_ASSERT_NEXT(a_insert_sets_valid, i_clk, i_rst_n, w_wr_en, r_valid[$past(w_sel)])
    `NHA_ASSERT_IMPL(a_age_never_zero, i_clk, i_rst_n, 1'b1, r_age_ctr != '0)
    `NHA_ASSERT_IMPL(a_no_write_on_hit, i_clk, i_rst_n, r_hit || w_bcast, !w_wr_en)
endmodule

>>> rtl/core/nha_ram.sv
// generic single write port ram with registered read
module nha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/core/nha_cfg_regs.sv
// apb configuration registers: net mask, gateway address, gateway present
module nha_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [nha_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [nha_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [nha_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready,
    output nha_pkg::t_cfg                     o_cfg
);
    nha_pkg::t_cfg r_cfg;
    logic          w_wr;
    logic [1:0]    w_idx;

    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[3:2];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_wr) begin
            case (w_idx)
                nha_pkg::REG_NET_MASK:   r_cfg.net_mask        <= pwdata;
                nha_pkg::REG_GATEWAY:    r_cfg.gateway_addr    <= pwdata;
                nha_pkg::REG_GW_PRESENT: r_cfg.gateway_present <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            nha_pkg::REG_NET_MASK:   prdata = r_cfg.net_mask;
            nha_pkg::REG_GATEWAY:    prdata = r_cfg.gateway_addr;
            nha_pkg::REG_GW_PRESENT: prdata = {{(nha_pkg::CFG_DATA_W-1){1'b0}},
                                               r_cfg.gateway_present};
            default:                 prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;
endmodule
